// ----- hw/rtl/alid_pkg.sv -----
// ----------------------------------------------------------------------------
// alid_pkg
// Shared sizes and codes for the array list insert/delete core.
// ----------------------------------------------------------------------------
package alid_pkg;

    // Maximum number of list entries (2 .. 127)
    localparam int CAPACITY = 64;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Fixed field widths of the beat payloads
    localparam int MODE_W   = 2;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Width wide enough to compare a position against count + 1
    localparam int CMP_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ----- hw/rtl/array_list_insert_delete_core.sv -----
// ----------------------------------------------------------------------------
// array_list_insert_delete_core
// Sequence: error and unused mode go straight to the result; read waits for
//   RAM read data; insert shifts the entries at or above the position up one
//   slot, then writes the value; delete scans every entry and refills each
//   matched slot from the tail. A held output register stalls the result.
// Throughput: one operation at a time; in_ready returns as the result registers.
// Reset: rst_n clears the count and control; RAM contents are not reset.
// ----------------------------------------------------------------------------
module array_list_insert_delete_core
    import alid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [POS_W-1:0]    position,
    input  logic signed [DATA_W-1:0] value,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  list_count,
    output logic [COUNT_W-1:0]  removed,
    output logic signed [DATA_W-1:0] read_data
);

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,  // wait for an input beat
        S_INS  = 7'b0000010,  // shift entries up, one per cycle
        S_PUT  = 7'b0000100,  // write the new value at its slot
        S_DEL  = 7'b0001000,  // compare the entry at idx with the value
        S_MOVE = 7'b0010000,  // write the last entry into the freed slot
        S_RDW  = 7'b0100000,  // wait for read data
        S_FIN  = 7'b1000000   // hand the result to the output register
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [ADDR_W-1:0]    wa_reg, wa_next;
    logic                 pend_reg, pend_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [DATA_W-1:0]    val_reg, val_next;
    logic [CNT_W-1:0]     gone_reg, gone_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [DATA_W-1:0]    res_rdata_reg, res_rdata_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [COUNT_W-1:0]   list_count_reg, list_count_next;
    logic [COUNT_W-1:0]   removed_reg, removed_next;
    logic [DATA_W-1:0]    read_data_reg, read_data_next;

    // RAM port signals
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]    ram_rdata;

    // Helpers
    logic                 in_fire;
    logic [CMP_W-1:0]     pos_in_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic                 shift_more;
    logic [CNT_W-1:0]     idx_inc;
    logic [CNT_W-1:0]     cnt_dec;
    logic                 hit;

    alid_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign pos_in_ext = CMP_W'(position);
    assign cnt_ext    = CMP_W'(cnt_reg);

    // Insert keeps shifting while the target slot is at or above the position
    assign shift_more = CMP_W'(idx_reg) >= CMP_W'(pos_reg);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign cnt_dec    = cnt_reg - CNT_W'(1);
    assign hit        = (ram_rdata == val_reg);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        wa_next         = wa_reg;
        pend_next       = pend_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        gone_next       = gone_reg;
        res_status_next = res_status_reg;
        res_rdata_next  = res_rdata_reg;

        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        list_count_next = list_count_reg;
        removed_next    = removed_reg;
        read_data_next  = read_data_reg;

        ram_we    = 1'b0;
        ram_waddr = wa_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = '0;

        // Drop the output beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pos_next        = position;
                    val_next        = value;
                    gone_next       = '0;
                    res_status_next = ST_OK;
                    res_rdata_next  = '0;
                    state_next      = S_FIN;
                    case (mode)
                        MODE_INSERT:
                        begin
                            // Position check comes before the full check
                            if (position == '0 || pos_in_ext > cnt_ext + CMP_W'(1))
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (cnt_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                idx_next   = cnt_reg;
                                pend_next  = 1'b0;
                                state_next = S_INS;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (cnt_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_DEL;
                            end
                        end
                        MODE_READ:
                        begin
                            if (position == '0 || pos_in_ext > cnt_ext)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ADDR_W'(position - POS_W'(1));
                                state_next = S_RDW;
                            end
                        end
                        default:
                        begin
                            // Unused code: report ok with no change
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                // Write back the entry fetched last cycle one slot higher
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg;
                    ram_wdata = ram_rdata;
                end
                if (shift_more)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(idx_reg - CNT_W'(1));
                    wa_next   = ADDR_W'(idx_reg);
                    pend_next = 1'b1;
                    idx_next  = idx_reg - CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_PUT;
                    end
                end
            end

            S_PUT:
            begin
                ram_we          = 1'b1;
                ram_waddr       = ADDR_W'(pos_reg - POS_W'(1));
                ram_wdata       = val_reg;
                cnt_next        = cnt_reg + CNT_W'(1);
                res_status_next = ST_OK;
                state_next      = S_FIN;
            end

            S_DEL:
            begin
                // Read data holds the current entry at idx
                if (hit)
                begin
                    gone_next = gone_reg + CNT_W'(1);
                    cnt_next  = cnt_dec;
                    if (idx_reg == cnt_dec)
                    begin
                        // Match was the last entry: nothing to move
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = ADDR_W'(cnt_dec);
                        state_next = S_MOVE;
                    end
                end
                else if (idx_inc < cnt_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(idx_inc);
                    idx_next  = idx_inc;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_MOVE:
            begin
                // Fill the hole; read data holds so the moved entry is checked next
                ram_we     = 1'b1;
                ram_waddr  = ADDR_W'(idx_reg);
                ram_wdata  = ram_rdata;
                state_next = S_DEL;
            end

            S_RDW:
            begin
                res_rdata_next = ram_rdata;
                state_next     = S_FIN;
            end

            S_FIN:
            begin
                // Hold here until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    list_count_next = COUNT_W'(cnt_reg);
                    removed_next    = COUNT_W'(gone_reg);
                    read_data_next  = res_rdata_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        wa_reg         <= wa_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        gone_reg       <= gone_next;
        res_status_reg <= res_status_next;
        res_rdata_reg  <= res_rdata_next;
        status_reg     <= status_next;
        list_count_reg <= list_count_next;
        removed_reg    <= removed_next;
        read_data_reg  <= read_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign list_count = list_count_reg;
    assign removed    = removed_reg;
    assign read_data  = read_data_reg;

endmodule

// ----- hw/rtl/alid_ram.sv -----
// ----------------------------------------------------------------------------
// alid_ram
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module alid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/alid_checker.sv -----
// ----------------------------------------------------------------------------
// alid_checker
// Port-level checks for the array list core, bound to the top level.
// ----------------------------------------------------------------------------
module alid_checker
    import alid_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [COUNT_W-1:0]  list_count,
    input logic [COUNT_W-1:0]  removed,
    input logic [DATA_W-1:0]   read_data
);

    // A failed operation removes nothing and returns no data
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> removed == '0 && read_data == '0)
        else $error("error beat carries removed count or read data");

    // Only the defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_RANGE || status == ST_FULL)
        else $error("undefined status code");

    // Data and removal are exclusive: a read removes nothing
    a_read_no_remove: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_data != '0 |-> removed == '0)
        else $error("beat reports both read data and removed entries");

    // A stalled result beat holds its valid, count and status
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(list_count) && $stable(status))
        else $error("result beat changed while stalled");

endmodule

bind array_list_insert_delete_core alid_checker u_alid_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .list_count (list_count),
    .removed    (removed),
    .read_data  (read_data)
);
